/* hdl/dmi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmi_pkg - shared definitions for the drag motion integrator
// Field widths, register reset values, register indexes and the control
// structures that pass between the sequencer and the serial multiplier.
// ----------------------------------------------------------------------------
package dmi_pkg;

   localparam int IN_W  = 16;          // input vector components, Q2.14
   localparam int DT_W  = 16;          // time step, Q0.16
   localparam int FG_W  = 32;          // force gain, Q16.16
   localparam int DC_W  = 16;          // drag coefficient, Q0.16
   localparam int OUT_W = 32;          // velocity, move, acceleration, Q16.16

   localparam logic [FG_W-1:0] FG_RESET = 32'd19660800;
   localparam logic [DC_W-1:0] DC_RESET = 16'd33;

   // register indexes on the csr port
   localparam logic CSR_FORCE_GAIN = 1'b0;
   localparam logic CSR_DRAG_COEFF = 1'b1;

   // serial multiplier geometry
   localparam int MA_W   = 48;         // multiplicand
   localparam int MB_W   = 32;         // multiplier, left aligned
   localparam int DIG_W  = 4;          // digit taken per cycle
   localparam int MP_W   = 64;         // product
   localparam int NDIG_W = 4;          // digit count

   typedef struct packed {
      logic              start;
      logic [NDIG_W-1:0] ndig;
   } mul_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

`default_nettype wire

/* hdl/dmi_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmi_req_if - request channel
// Time step and input vector, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dmi_req_if import dmi_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic        [DT_W-1:0] dt;
   logic signed [IN_W-1:0] in_x;
   logic signed [IN_W-1:0] in_y;
   logic signed [IN_W-1:0] in_z;

   modport source (output valid, dt, in_x, in_y, in_z, input ready);
   modport sink   (input valid, dt, in_x, in_y, in_z, output ready);
endinterface

`default_nettype wire

/* hdl/dmi_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmi_rsp_if - response channel
// New velocity and move for one step, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dmi_rsp_if import dmi_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] vel_x;
   logic signed [OUT_W-1:0] vel_y;
   logic signed [OUT_W-1:0] vel_z;
   logic signed [OUT_W-1:0] move_x;
   logic signed [OUT_W-1:0] move_y;
   logic signed [OUT_W-1:0] move_z;

   modport source (output valid, vel_x, vel_y, vel_z, move_x, move_y, move_z,
                   input ready);
   modport sink   (input valid, vel_x, vel_y, vel_z, move_x, move_y, move_z,
                   output ready);
endinterface

`default_nettype wire

/* hdl/dmi_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmi_mul - digit serial unsigned multiplier
// Takes the multiplier four bits a cycle, most significant digit first, and
// accumulates shifted partial products. Done pulses once the product is final.
// ----------------------------------------------------------------------------
module dmi_mul import dmi_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mul_ctl_type       ctl,
   input  wire logic [MA_W-1:0]   a,
   input  wire logic [MB_W-1:0]   b,
   output mul_stat_type           stat,
   output logic      [MP_W-1:0]   prod
);

   logic [MA_W-1:0]       a_ff;
   logic [MB_W-1:0]       b_ff;
   logic [MP_W-1:0]       acc_ff;
   logic [MP_W-1:0]       acc_in;
   logic [NDIG_W-1:0]     cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [MA_W+DIG_W-1:0] part;

   always_comb begin
      part   = a_ff * b_ff[MB_W-1 -: DIG_W];
      acc_in = {acc_ff[MP_W-DIG_W-1:0], {DIG_W{1'b0}}} + MP_W'(part);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= ctl.ndig;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == NDIG_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         b_ff   <= {b_ff[MB_W-DIG_W-1:0], {DIG_W{1'b0}}};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign prod      = acc_ff;

endmodule

`default_nettype wire

/* hdl/drag_motion_integrator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drag_motion_integrator - point mass step under input force and square drag
// Clamps the input vector to unit length, scales it by the force gain,
// subtracts quadratic drag and advances velocity by the trapezoid rule.
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  req_bus   in         valid/ready    dt, in_x, in_y, in_z
//  rsp_bus   out        valid/ready    vel_x/y/z, move_x/y/z
//  csr_*     in         write enable   csr_index, csr_wdata
//
//  One item at a time: a new request is taken only once the last result has
//  gone to the response register. The shared 4-bit digit multiplier forms
//  all 24 products of an item in turn; the clamp adds a bit serial square
//  root and a divide on three lanes.
//  Reset gives zero velocity and acceleration and the default registers.
//  A waiting response does not block the next request; only its write-back
//  waits for the response register to empty.
// ----------------------------------------------------------------------------
module drag_motion_integrator import dmi_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_we,
   input  wire logic            csr_index,
   input  wire logic [FG_W-1:0] csr_wdata,
   dmi_req_if.sink              req_bus,
   dmi_rsp_if.source            rsp_bus
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQ   = 4'd1;
   localparam logic [3:0] S_SQRT = 4'd2;
   localparam logic [3:0] S_DIV  = 4'd3;
   localparam logic [3:0] S_AIN  = 4'd4;
   localparam logic [3:0] S_VSQ  = 4'd5;
   localparam logic [3:0] S_DRAG = 4'd6;
   localparam logic [3:0] S_VEL  = 4'd7;
   localparam logic [3:0] S_AM1  = 4'd8;
   localparam logic [3:0] S_AM2  = 4'd9;
   localparam logic [3:0] S_MOVE = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
   localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

   function automatic logic signed [OUT_W-1:0] sat32(input logic signed [48:0] x);
      if (x > SAT_HI)
         return SAT_HI[OUT_W-1:0];
      else if (x < SAT_LO)
         return SAT_LO[OUT_W-1:0];
      else
         return x[OUT_W-1:0];
   endfunction

   logic [3:0]              state_ff;
   logic                    iss_ff;
   logic [1:0]              ax_ff;
   logic [4:0]              cnt_ff;
   logic [FG_W-1:0]         fg_ff;
   logic [DC_W-1:0]         dc_ff;
   logic signed [OUT_W-1:0] vel_ff [3];
   logic signed [OUT_W-1:0] acc_ff [3];
   logic [DT_W-1:0]         dt_ff;
   logic                    sgn_ff [3];
   logic [15:0]             mag_ff [3];
   logic [31:0]             sq_ff;
   logic [47:0]             rad_ff;
   logic [25:0]             srem_ff;
   logic [23:0]             root_ff;
   logic [23:0]             drem_ff [3];
   logic signed [35:0]      ain_ff;
   logic [46:0]             r1_ff;
   logic signed [OUT_W-1:0] na_ff;
   logic signed [OUT_W-1:0] nv_ff;
   logic [47:0]             p1_ff;
   logic [30:0]             am_ff;
   logic signed [OUT_W-1:0] resv_ff [3];
   logic signed [OUT_W-1:0] resm_ff [3];
   logic signed [OUT_W-1:0] ov_ff [3];
   logic signed [OUT_W-1:0] om_ff [3];
   logic                    rsp_v_ff;

   mul_ctl_type       mul_ctl;
   mul_stat_type      mul_stat;
   logic [MA_W-1:0]   mul_a;
   logic [MB_W-1:0]   mul_b;
   logic [MP_W-1:0]   prod;
   logic              is_mul;
   logic              take;

   logic signed [OUT_W-1:0] vcur;
   logic signed [OUT_W-1:0] acur;
   logic [31:0]             vm;
   logic signed [32:0]      sum_a;
   logic [32:0]             smag;
   logic [31:0]             namag;
   logic [31:0]             nvmag;
   logic [31:0]             sq_sum;
   logic [27:0]             srem_sh;
   logic [27:0]             trial;
   logic [34:0]             ainm;
   logic signed [35:0]      ain_in;
   logic [46:0]             rnd16;
   logic signed [48:0]      drag49;
   logic signed [OUT_W-1:0] na_in;
   logic [31:0]             tv;
   logic signed [33:0]      nv34;
   logic signed [OUT_W-1:0] nv_in;
   logic [30:0]             am_in;
   logic [31:0]             tm;
   logic signed [33:0]      mv34;
   logic signed [OUT_W-1:0] mv_in;
   logic                    out_load;

   dmi_mul u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_ctl),
      .a     (mul_a),
      .b     (mul_b),
      .stat  (mul_stat),
      .prod  (prod)
   );

   // current axis operands
   always_comb begin
      vcur  = vel_ff[ax_ff];
      acur  = acc_ff[ax_ff];
      vm    = vcur[OUT_W-1] ? 32'(-vcur) : 32'(vcur);
      sum_a = {acur[OUT_W-1], acur} + {na_ff[OUT_W-1], na_ff};
      smag  = sum_a[32] ? 33'(-sum_a) : 33'(sum_a);
      namag = na_ff[OUT_W-1] ? 32'(-na_ff) : 32'(na_ff);
      nvmag = nv_ff[OUT_W-1] ? 32'(-nv_ff) : 32'(nv_ff);
   end

   // multiplier operand selection
   always_comb begin
      is_mul = state_ff inside {S_SQ, S_AIN, S_VSQ, S_DRAG, S_VEL, S_AM1, S_AM2, S_MOVE};
      mul_ctl.start = is_mul && !iss_ff;
      mul_ctl.ndig  = NDIG_W'(4);
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQ: begin
            mul_a = MA_W'(mag_ff[ax_ff]);
            mul_b = {mag_ff[ax_ff], 16'd0};
         end
         S_AIN: begin
            mul_a = MA_W'(fg_ff);
            mul_b = {mag_ff[ax_ff], 16'd0};
         end
         S_VSQ: begin
            mul_a = MA_W'(vm);
            mul_b = vm;
            mul_ctl.ndig = NDIG_W'(8);
         end
         S_DRAG: begin
            mul_a = MA_W'(r1_ff);
            mul_b = {dc_ff, 16'd0};
         end
         S_VEL: begin
            mul_a = MA_W'(smag);
            mul_b = {dt_ff, 16'd0};
         end
         S_AM1: begin
            mul_a = MA_W'(namag);
            mul_b = {dt_ff, 16'd0};
         end
         S_AM2: begin
            mul_a = p1_ff;
            mul_b = {dt_ff, 16'd0};
         end
         S_MOVE: begin
            mul_a = MA_W'(nvmag);
            mul_b = {dt_ff, 16'd0};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      take = iss_ff && mul_stat.done;
   end

   // arithmetic on the finished product
   always_comb begin
      sq_sum  = sq_ff + prod[31:0];
      srem_sh = {srem_ff, rad_ff[47:46]};
      trial   = {2'b00, root_ff, 2'b01};

      ainm   = {1'b0, prod[47:14]} + 35'(prod[13]);
      ain_in = sgn_ff[ax_ff] ? -$signed({1'b0, ainm}) : $signed({1'b0, ainm});

      rnd16  = prod[62:16] + 47'(prod[15]);
      drag49 = vcur[OUT_W-1] ? -$signed({2'b00, rnd16}) : $signed({2'b00, rnd16});
      na_in  = sat32(49'(ain_ff) - drag49);

      tv    = {1'b0, prod[47:17]} + 32'(prod[16]);
      nv34  = 34'(vcur) + (sum_a[32] ? -$signed({2'b00, tv}) : $signed({2'b00, tv}));
      nv_in = sat32(49'(nv34));

      am_in = {1'b0, prod[62:33]} + 31'(prod[32]);

      tm    = prod[47:16] + 32'(prod[15]);
      mv34  = (nv_ff[OUT_W-1] ? -$signed({2'b00, tm}) : $signed({2'b00, tm}))
            + (na_ff[OUT_W-1] ? -$signed({3'b000, am_ff}) : $signed({3'b000, am_ff}));
      mv_in = sat32(49'(mv34));

      out_load = (state_ff == S_OUT) && (!rsp_v_ff || rsp_bus.ready);
   end

   assign req_bus.ready = (state_ff == S_IDLE);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         dc_ff <= DC_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FORCE_GAIN: fg_ff <= csr_wdata;
            CSR_DRAG_COEFF: dc_ff <= csr_wdata[DC_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iss_ff   <= 1'b0;
         ax_ff    <= '0;
         cnt_ff   <= '0;
         rsp_v_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            vel_ff[i] <= '0;
            acc_ff[i] <= '0;
         end
      end else begin
         if (mul_ctl.start)
            iss_ff <= 1'b1;
         else if (take)
            iss_ff <= 1'b0;

         if (out_load)
            rsp_v_ff <= 1'b1;
         else if (rsp_bus.ready)
            rsp_v_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_bus.valid) begin
                  ax_ff    <= '0;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               if (take) begin
                  if (ax_ff == 2'd2) begin
                     ax_ff <= '0;
                     if (sq_sum > 32'h1000_0000) begin
                        cnt_ff   <= 5'd23;
                        state_ff <= S_SQRT;
                     end else begin
                        state_ff <= S_AIN;
                     end
                  end else begin
                     ax_ff <= ax_ff + 1'b1;
                  end
               end
            end
            S_SQRT: begin
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  cnt_ff   <= 5'd15;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0)
                  state_ff <= S_AIN;
            end
            S_AIN:  if (take) state_ff <= S_VSQ;
            S_VSQ:  if (take) state_ff <= S_DRAG;
            S_DRAG: if (take) state_ff <= S_VEL;
            S_VEL:  if (take) state_ff <= S_AM1;
            S_AM1:  if (take) state_ff <= S_AM2;
            S_AM2:  if (take) state_ff <= S_MOVE;
            S_MOVE: begin
               if (take) begin
                  vel_ff[ax_ff] <= nv_ff;
                  acc_ff[ax_ff] <= na_ff;
                  if (ax_ff == 2'd2) begin
                     state_ff <= S_OUT;
                  end else begin
                     ax_ff    <= ax_ff + 1'b1;
                     state_ff <= S_AIN;
                  end
               end
            end
            S_OUT: begin
               // hold until the response register is free
               if (out_load)
                  state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_bus.valid) begin
         dt_ff     <= req_bus.dt;
         sgn_ff[0] <= req_bus.in_x[IN_W-1];
         sgn_ff[1] <= req_bus.in_y[IN_W-1];
         sgn_ff[2] <= req_bus.in_z[IN_W-1];
         mag_ff[0] <= req_bus.in_x[IN_W-1] ? 16'(-req_bus.in_x) : 16'(req_bus.in_x);
         mag_ff[1] <= req_bus.in_y[IN_W-1] ? 16'(-req_bus.in_y) : 16'(req_bus.in_y);
         mag_ff[2] <= req_bus.in_z[IN_W-1] ? 16'(-req_bus.in_z) : 16'(req_bus.in_z);
         sq_ff     <= '0;
      end

      if (state_ff == S_SQ && take) begin
         sq_ff   <= sq_sum;
         rad_ff  <= {sq_sum, 16'd0};
         srem_ff <= '0;
         root_ff <= '0;
      end

      // one root bit per cycle
      if (state_ff == S_SQRT) begin
         rad_ff <= {rad_ff[45:0], 2'b00};
         if (srem_sh >= trial) begin
            srem_ff <= 26'(srem_sh - trial);
            root_ff <= {root_ff[22:0], 1'b1};
         end else begin
            srem_ff <= srem_sh[25:0];
            root_ff <= {root_ff[22:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            for (int i = 0; i < 3; i++)
               drem_ff[i] <= {2'b00, mag_ff[i], 6'd0};
         end
      end

      // one quotient bit per cycle on each lane
      if (state_ff == S_DIV) begin
         for (int i = 0; i < 3; i++) begin
            if ({drem_ff[i], 1'b0} >= {1'b0, root_ff}) begin
               drem_ff[i] <= 24'({drem_ff[i], 1'b0} - {1'b0, root_ff});
               mag_ff[i]  <= {mag_ff[i][14:0], 1'b1};
            end else begin
               drem_ff[i] <= {drem_ff[i][22:0], 1'b0};
               mag_ff[i]  <= {mag_ff[i][14:0], 1'b0};
            end
         end
      end

      if (take) begin
         case (state_ff)
            S_AIN:  ain_ff <= ain_in;
            S_VSQ:  r1_ff  <= rnd16;
            S_DRAG: na_ff  <= na_in;
            S_VEL:  nv_ff  <= nv_in;
            S_AM1:  p1_ff  <= prod[47:0];
            S_AM2:  am_ff  <= am_in;
            S_MOVE: begin
               resv_ff[ax_ff] <= nv_ff;
               resm_ff[ax_ff] <= mv_in;
            end
            default: ;
         endcase
      end

      if (out_load) begin
         for (int i = 0; i < 3; i++) begin
            ov_ff[i] <= resv_ff[i];
            om_ff[i] <= resm_ff[i];
         end
      end
   end

   assign rsp_bus.valid  = rsp_v_ff;
   assign rsp_bus.vel_x  = ov_ff[0];
   assign rsp_bus.vel_y  = ov_ff[1];
   assign rsp_bus.vel_z  = ov_ff[2];
   assign rsp_bus.move_x = om_ff[0];
   assign rsp_bus.move_y = om_ff[1];
   assign rsp_bus.move_z = om_ff[2];

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> iss_ff)
      else $error("multiplier finished with no product pending");

   a_busy_expected: assert property (@(posedge clock) disable iff (reset)
      mul_stat.busy |-> (iss_ff && is_mul))
      else $error("multiplier running outside a product step");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (root_ff[23:22] != 2'b00))
      else $error("clamp length below unit scale");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      ax_ff != 2'd3)
      else $error("axis index out of range");

endmodule

`default_nettype wire
